// ----- rtl/wuf_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted union-find package
// Shared payload types, command and status bundles and fixed field widths.
// ----------------------------------------------------------------------------
package wuf_pkg;

	// Node indexes on the request and result fields, and stored parent links.
	localparam int NODE_W = 10;
	// Set sizes held at each root.
	localparam int SIZE_W = 11;

	typedef enum logic {
		OP_UNION = 1'b0,
		OP_QUERY = 1'b1
	} wuf_op_t;

	typedef struct packed {
		wuf_op_t           op;
		logic [NODE_W-1:0] node_first;
		logic [NODE_W-1:0] node_second;
	} wuf_req_t;

	typedef struct packed {
		logic              same_set;
		logic [NODE_W-1:0] root_first;
		logic [NODE_W-1:0] root_second;
	} wuf_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic idle;     // ready for a new request
		logic load;     // capture the request, start the first walk
		logic issue;    // read the parent of the current node
		logic advance;  // step up to the parent just read and read its parent
		logic take_a;   // current node is the first root, start the second walk
		logic take_b;   // current node is the second root
		logic size_a;   // read the size of the first root
		logic size_b;   // hold the first size, read the size of the second root
		logic link;     // attach the smaller root and write the summed size
		logic emit;     // load the result register
		logic clear;    // write one entry of the reset pattern
	} wuf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_oor;     // current node lies outside the store
		logic at_root;     // the parent just read ends the walk
		logic roots_link;  // union of two distinct in-range roots
		logic clear_last;  // clearing pass is on its last entry
		logic out_free;    // result register can take a new result
	} wuf_status_t;

endpackage

// ----- rtl/wuf_stream_if.sv -----
// ----------------------------------------------------------------------------
// Weighted union-find stream interface
// Valid/ready channel carrying one payload per handshake.
// ----------------------------------------------------------------------------
interface wuf_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/wuf_datapath.sv -----
// ----------------------------------------------------------------------------
// Weighted union-find datapath
// Parent and size memories, walk registers, linking logic and result register.
// ----------------------------------------------------------------------------
module wuf_datapath import wuf_pkg::*; #(
	parameter int NODE_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  wuf_cmd_t    cmd,
	output wuf_status_t status,
	input  wuf_req_t    req_payload,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output wuf_rsp_t    rsp_payload
);

	localparam int ADDR_W = $clog2(NODE_COUNT);

	logic [NODE_W-1:0] parent_mem [NODE_COUNT];
	logic [SIZE_W-1:0] size_mem   [NODE_COUNT];

	wuf_op_t           op_q;
	logic [NODE_W-1:0] node_b_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] root_a_q;
	logic [NODE_W-1:0] root_b_q;
	logic [NODE_W-1:0] prd_q;
	logic [SIZE_W-1:0] srd_q;
	logic [SIZE_W-1:0] sz_a_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              rsp_valid_q;
	wuf_rsp_t          rsp_q;

	logic              a_wins;
	logic [SIZE_W-1:0] size_sum;
	logic [ADDR_W-1:0] p_raddr;
	logic [ADDR_W-1:0] s_raddr;
	logic              p_we;
	logic [ADDR_W-1:0] p_waddr;
	logic [NODE_W-1:0] p_wdata;
	logic [ADDR_W-1:0] s_waddr;
	logic [SIZE_W-1:0] s_wdata;

	always_comb begin
		status.cur_oor    = 32'(cur_q) >= NODE_COUNT;
		status.at_root    = (prd_q == cur_q) || (32'(prd_q) >= NODE_COUNT);
		status.roots_link = (op_q == OP_UNION) && (root_a_q != root_b_q) &&
			(32'(root_a_q) < NODE_COUNT) && (32'(root_b_q) < NODE_COUNT);
		status.clear_last = clr_cnt_q == ADDR_W'(NODE_COUNT - 1);
		status.out_free   = !rsp_valid_q || rsp_ready;
	end

	// On equal sizes the second root goes under the first.
	assign a_wins   = sz_a_q >= srd_q;
	assign size_sum = sz_a_q + srd_q;

	assign p_raddr = cmd.advance ? ADDR_W'(prd_q) : ADDR_W'(cur_q);
	assign s_raddr = cmd.size_a ? ADDR_W'(root_a_q) : ADDR_W'(root_b_q);

	always_comb begin
		p_we = cmd.clear || cmd.link;
		if (cmd.clear) begin
			p_waddr = clr_cnt_q;
			p_wdata = NODE_W'(clr_cnt_q);
			s_waddr = clr_cnt_q;
			s_wdata = SIZE_W'(1);
		end else begin
			p_waddr = a_wins ? ADDR_W'(root_b_q) : ADDR_W'(root_a_q);
			p_wdata = a_wins ? root_a_q : root_b_q;
			s_waddr = a_wins ? ADDR_W'(root_a_q) : ADDR_W'(root_b_q);
			s_wdata = size_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			parent_mem[p_waddr] <= p_wdata;
		end
		prd_q <= parent_mem[p_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			size_mem[s_waddr] <= s_wdata;
		end
		srd_q <= size_mem[s_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req_payload.op;
			node_b_q <= req_payload.node_second;
			cur_q    <= req_payload.node_first;
		end else if (cmd.advance) begin
			cur_q <= prd_q;
		end else if (cmd.take_a) begin
			root_a_q <= cur_q;
			cur_q    <= node_b_q;
		end else if (cmd.take_b) begin
			root_b_q <= cur_q;
		end
		if (cmd.size_b) begin
			sz_a_q <= srd_q;
		end
		if (cmd.emit) begin
			rsp_q.same_set    <= root_a_q == root_b_q;
			rsp_q.root_first  <= root_a_q;
			rsp_q.root_second <= root_b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_payload = rsp_q;

	// A link never ties a root to itself and never grows a set past the store.
	a_link_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> (root_a_q != root_b_q))
		else $error("link issued for identical roots");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> (32'(sz_a_q) + 32'(srd_q) <= NODE_COUNT))
		else $error("merged set size exceeds node count");

	// A result is never overwritten before it is taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten while pending");

endmodule

// ----- rtl/wuf_controller.sv -----
// ----------------------------------------------------------------------------
// Weighted union-find controller
// Sequences clearing, the two root walks, linking and result hand-off.
// ----------------------------------------------------------------------------
module wuf_controller import wuf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  wuf_status_t status,
	output wuf_cmd_t    cmd
);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b00_0000_0001,
		S_IDLE    = 10'b00_0000_0010,
		S_ISSUE_A = 10'b00_0000_0100,
		S_CHECK_A = 10'b00_0000_1000,
		S_ISSUE_B = 10'b00_0001_0000,
		S_CHECK_B = 10'b00_0010_0000,
		S_DECIDE  = 10'b00_0100_0000,
		S_SIZE_A  = 10'b00_1000_0000,
		S_SIZE_B  = 10'b01_0000_0000,
		S_LINK    = 10'b10_0000_0000
	} wuf_state_t;

	wuf_state_t state_q;
	wuf_state_t state_d;
	logic       done_q;
	logic       done_d;

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				// The finished result is handed to the result register here,
				// which leaves the store free for the next request.
				if (done_q) begin
					if (status.out_free) begin
						cmd.emit = 1'b1;
						done_d   = 1'b0;
					end
				end else begin
					cmd.idle = 1'b1;
					if (req_valid) begin
						cmd.load = 1'b1;
						state_d  = S_ISSUE_A;
					end
				end
			end
			S_ISSUE_A: begin
				if (status.cur_oor) begin
					cmd.take_a = 1'b1;
					state_d    = S_ISSUE_B;
				end else begin
					cmd.issue = 1'b1;
					state_d   = S_CHECK_A;
				end
			end
			S_CHECK_A: begin
				if (status.at_root) begin
					cmd.take_a = 1'b1;
					state_d    = S_ISSUE_B;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_ISSUE_B: begin
				if (status.cur_oor) begin
					cmd.take_b = 1'b1;
					state_d    = S_DECIDE;
				end else begin
					cmd.issue = 1'b1;
					state_d   = S_CHECK_B;
				end
			end
			S_CHECK_B: begin
				if (status.at_root) begin
					cmd.take_b = 1'b1;
					state_d    = S_DECIDE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_DECIDE: begin
				done_d = 1'b1;
				if (status.roots_link) begin
					state_d = S_SIZE_A;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SIZE_A: begin
				cmd.size_a = 1'b1;
				state_d    = S_SIZE_B;
			end
			S_SIZE_B: begin
				cmd.size_b = 1'b1;
				state_d    = S_LINK;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.issue, cmd.advance, cmd.take_a, cmd.take_b,
			cmd.size_a, cmd.size_b, cmd.link, cmd.emit, cmd.clear}))
		else $error("more than one datapath command at once");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !cmd.idle)
		else $error("controller ready again right after taking a request");

	a_no_clear_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idle |=> !cmd.clear)
		else $error("clearing pass restarted after reaching idle");

endmodule

// ----- rtl/weighted_union_find.sv -----
// ----------------------------------------------------------------------------
// Weighted union-find engine
// Disjoint-set engine with weighted quick-union linking over a fixed store.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NODE_COUNT entries that
// makes every node its own root with a set size of one; req.ready stays low
// during that pass. Each request names an operation and two nodes. Both nodes
// are walked up their parent links to their roots, one memory read per level,
// and one result comes back per request with the two roots and whether they
// were already the same. A union of two different roots hangs the root of the
// smaller set under the larger one (the second under the first on a tie) and
// sums the sizes. A node index at or above NODE_COUNT counts as a lone root
// that no union touches, and its walk ends without a memory read. One request
// is worked at a time; the depth of a node in its tree is at most log2 of
// NODE_COUNT with weighted linking. The next request can be accepted in the
// cycle after the result is loaded. The two walks share the single read port
// of the parent memory. The result load also waits while an earlier result
// still sits untaken in the result register. A result waits in its own
// register, so the next request is accepted while an earlier result is still
// pending on the rsp channel.
// ----------------------------------------------------------------------------
module weighted_union_find import wuf_pkg::*; #(
	parameter int NODE_COUNT = 1024
) (
	input logic                clk,
	input logic                arst_n,
	wuf_stream_if.sink         req,
	wuf_stream_if.source       rsp
);

	wuf_cmd_t    cmd;
	wuf_status_t status;

	// Requests are taken only while the controller sits idle with no
	// finished result still to be placed in the result register.
	assign req.ready = cmd.idle;

	wuf_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.status    (status),
		.cmd       (cmd)
	);

	wuf_datapath #(
		.NODE_COUNT (NODE_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_payload (req.payload),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_payload (rsp.payload)
	);

endmodule
